### hdl/rch_pkg.sv
// rch_pkg: shared types and constants for the rgb color histogram unit
// no dependencies; imported by the front end, the item queue and the back end
package rch_pkg;

    localparam int DEF_QUANT_STEP = 64;
    localparam int DEF_LEVELS     = 4;
    localparam int DEF_BIN_COUNT  = 64;
    localparam int DEF_COUNT_BITS = 32;

    // widest bin index the queue carries (largest supported bin count is 4096)
    localparam int BIN_IDX_MAX_W = 12;
    localparam int QUEUE_DEPTH   = 4;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef struct packed {
        op_t                      kind;
        logic [BIN_IDX_MAX_W-1:0] bin;
        logic                     in_range;
    } rch_item_t;

    typedef enum logic [1:0] {
        BK_INIT,
        BK_RUN,
        BK_CLEAR
    } back_state_t;

endpackage

### hdl/rgb_color_histogram_unit.sv
// rgb_color_histogram_unit: top level of the quantized rgb color histogram
// depends on rch_pkg, rch_front, rch_queue and rch_back
//
//  channel | signals                                       | dir
//  --------+-----------------------------------------------+-----
//  in      | in_valid, in_ready, op, red, green, blue,     | in
//          | read_bin                                      |
//  out     | out_valid, out_ready, bin_number, bin_count,  | out
//          | pixel_total                                   |
//
// the back end takes a new add or read item before the last one is written back;
// forwarding covers back-to-back adds to one bin of the single-write-port bin memory
// a clear item sweeps the bin memory while the queue still fills
// after reset the same sweep runs with in_ready held low
// a read result waits in the output register; a stall there holds the pipeline
// only while a further read needs that register
module rgb_color_histogram_unit
    import rch_pkg::*;
#(
    parameter int QUANT_STEP = DEF_QUANT_STEP,
    parameter int LEVELS     = DEF_LEVELS,
    parameter int BIN_COUNT  = DEF_BIN_COUNT,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [5:0]  read_bin,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  bin_number,
    output logic [31:0] bin_count,
    output logic [31:0] pixel_total
);

    logic      accept_en;
    logic      q_full;
    logic      q_push;
    rch_item_t q_item;
    logic      head_valid;
    rch_item_t head_item;
    logic      pop;

    rch_front #(
        .QUANT_STEP (QUANT_STEP),
        .LEVELS     (LEVELS),
        .BIN_COUNT  (BIN_COUNT)
    ) u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .read_bin  (read_bin),
        .accept_en (accept_en),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_item)
    );

    rch_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item),
        .full       (q_full)
    );

    rch_back #(
        .BIN_COUNT  (BIN_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_item   (head_item),
        .pop         (pop),
        .accept_en   (accept_en),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .bin_number  (bin_number),
        .bin_count   (bin_count),
        .pixel_total (pixel_total)
    );

endmodule

### hdl/rch_front.sv
// rch_front: accepts input transfers and turns each clear, add or read into a queue item
// depends on rch_pkg; feeds rch_queue
module rch_front
    import rch_pkg::*;
#(
    parameter int QUANT_STEP = DEF_QUANT_STEP,
    parameter int LEVELS     = DEF_LEVELS,
    parameter int BIN_COUNT  = DEF_BIN_COUNT
) (
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] op,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic [5:0] read_bin,
    input  logic       accept_en,
    input  logic       q_full,
    output logic       q_push,
    output rch_item_t  q_item
);

    // quotient by the step is a multiply by the rounded-up reciprocal and a shift,
    // exact for any step up to 256 on 8-bit channels
    localparam int QR_SHIFT = 16;
    localparam int QRECIP   = ((1 << QR_SHIFT) + QUANT_STEP - 1) / QUANT_STEP;
    localparam int IDX_W    = 25;

    logic [IDX_W-1:0] q_red;
    logic [IDX_W-1:0] q_green;
    logic [IDX_W-1:0] q_blue;
    logic [IDX_W-1:0] pix_idx;
    logic             accepted;

    assign in_ready = accept_en && !q_full;
    assign accepted = in_valid && in_ready;

    assign q_red   = (IDX_W'(red) * IDX_W'(QRECIP)) >> QR_SHIFT;
    assign q_green = (IDX_W'(green) * IDX_W'(QRECIP)) >> QR_SHIFT;
    assign q_blue  = (IDX_W'(blue) * IDX_W'(QRECIP)) >> QR_SHIFT;
    assign pix_idx = q_red * IDX_W'(LEVELS * LEVELS) + q_green * IDX_W'(LEVELS) + q_blue;

    always_comb
    begin
        q_push        = 1'b0;
        q_item.kind   = OP_CLEAR;
        q_item.bin    = '0;
        q_item.in_range = 1'b0;
        unique case (op)
            OP_CLEAR:
            begin
                q_push = accepted;
            end
            OP_ADD:
            begin
                q_push          = accepted;
                q_item.kind     = OP_ADD;
                q_item.bin      = BIN_IDX_MAX_W'(pix_idx);
                q_item.in_range = pix_idx < IDX_W'(BIN_COUNT);
            end
            OP_READ:
            begin
                q_push          = accepted;
                q_item.kind     = OP_READ;
                q_item.bin      = BIN_IDX_MAX_W'(read_bin);
                q_item.in_range = 32'(read_bin) < 32'(BIN_COUNT);
            end
            // unused op code is taken and dropped
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

endmodule

### hdl/rch_queue.sv
// rch_queue: short item queue between front end and back end
// depends on rch_pkg
module rch_queue
    import rch_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  rch_item_t push_item,
    input  logic      pop,
    output logic      head_valid,
    output rch_item_t head_item,
    output logic      full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    rch_item_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign head_valid = count_reg != '0;
    assign full       = count_reg == CNT_W'(QUEUE_DEPTH);
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hdl/rch_back.sv
// rch_back: bin memory, read-modify-write pipeline, pixel total and result register
// depends on rch_pkg; drains rch_queue
module rch_back
    import rch_pkg::*;
#(
    parameter int BIN_COUNT  = DEF_BIN_COUNT,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  rch_item_t   head_item,
    output logic        pop,
    output logic        accept_en,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  bin_number,
    output logic [31:0] bin_count,
    output logic [31:0] pixel_total
);

    localparam int BIN_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

    function automatic logic [31:0] clip32(input logic [63:0] v);
        return (v > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    logic [COUNT_BITS-1:0] mem [BIN_COUNT];

    back_state_t           state_reg;
    back_state_t           state_next;
    logic [BIN_W-1:0]      sweep_reg;
    logic [BIN_W-1:0]      sweep_next;
    logic                  s2_valid_reg;
    logic                  s2_valid_next;
    rch_item_t             s2_item_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  lw_valid_reg;
    logic                  lw_valid_next;
    logic [BIN_W-1:0]      lw_bin_reg;
    logic [COUNT_BITS-1:0] lw_val_reg;
    logic [COUNT_BITS-1:0] total_reg;
    logic [COUNT_BITS-1:0] total_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [5:0]            bin_number_reg;
    logic [31:0]           bin_count_reg;
    logic [31:0]           pixel_total_reg;

    logic                  sweeping;
    logic                  s2_go;
    logic                  s2_write;
    logic [BIN_W-1:0]      s2_bin;
    logic [BIN_W-1:0]      head_bin;
    logic [COUNT_BITS-1:0] s2_data;
    logic [COUNT_BITS-1:0] s2_inc;
    logic [COUNT_BITS-1:0] total_inc;
    logic                  adv;
    logic                  head_is_clear;

    assign accept_en   = state_reg != BK_INIT;
    assign sweeping    = state_reg == BK_INIT || state_reg == BK_CLEAR;
    assign out_valid   = out_valid_reg;
    assign bin_number  = bin_number_reg;
    assign bin_count   = bin_count_reg;
    assign pixel_total = pixel_total_reg;

    assign s2_bin   = s2_item_reg.bin[BIN_W-1:0];
    assign head_bin = head_item.bin[BIN_W-1:0];
    // the write issued at the same edge as this item's read is not in rd_data_reg
    assign s2_data  = (lw_valid_reg && lw_bin_reg == s2_bin) ? lw_val_reg : rd_data_reg;
    assign s2_inc   = (&s2_data) ? s2_data : s2_data + 1'b1;
    assign total_inc = (&total_reg) ? total_reg : total_reg + 1'b1;

    assign s2_go = s2_valid_reg
                && (s2_item_reg.kind != OP_READ || !out_valid_reg || out_ready);
    assign s2_write = s2_go && s2_item_reg.kind == OP_ADD && s2_item_reg.in_range;
    assign head_is_clear = head_item.kind == OP_CLEAR;
    assign adv = state_reg == BK_RUN && head_valid && (!s2_valid_reg || s2_go);
    assign pop = adv;

    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        s2_valid_next  = s2_valid_reg;
        lw_valid_next  = lw_valid_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg;

        unique case (state_reg)
            BK_INIT, BK_CLEAR:
            begin
                lw_valid_next = 1'b0;
                if (sweep_reg == BIN_W'(BIN_COUNT - 1))
                begin
                    sweep_next = '0;
                    state_next = BK_RUN;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            BK_RUN:
            begin
                if (s2_write)
                begin
                    lw_valid_next = 1'b1;
                end
                if (s2_go && s2_item_reg.kind == OP_ADD)
                begin
                    total_next = total_inc;
                end
                if (s2_go)
                begin
                    s2_valid_next = 1'b0;
                end
                if (adv)
                begin
                    if (head_is_clear)
                    begin
                        state_next    = BK_CLEAR;
                        total_next    = '0;
                        s2_valid_next = 1'b0;
                    end
                    else
                    begin
                        s2_valid_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = BK_INIT;
            end
        endcase

        if (s2_go && s2_item_reg.kind == OP_READ)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_INIT;
            sweep_reg     <= '0;
            s2_valid_reg  <= 1'b0;
            lw_valid_reg  <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            s2_valid_reg  <= s2_valid_next;
            lw_valid_reg  <= lw_valid_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // bin memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (sweeping)
        begin
            mem[sweep_reg] <= '0;
        end
        else if (s2_write)
        begin
            mem[s2_bin] <= s2_inc;
        end
        if (adv)
        begin
            rd_data_reg <= mem[head_bin];
            s2_item_reg <= head_item;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_write)
        begin
            lw_bin_reg <= s2_bin;
            lw_val_reg <= s2_inc;
        end
        if (s2_go && s2_item_reg.kind == OP_READ)
        begin
            bin_number_reg  <= s2_item_reg.bin[5:0];
            bin_count_reg   <= s2_item_reg.in_range ? clip32(64'(s2_data)) : 32'd0;
            pixel_total_reg <= clip32(64'(total_reg));
        end
    end

endmodule
